// ----- rtl/mp22_pkg.sv -----
// Shared constants, types and the float compare for the 2x2 max pooling block.
package mp22_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int HALF_DEPTH = MAX_WIDTH / 2;
  localparam int SLOT_W     = $clog2(HALF_DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WREG_W     = 13;
  localparam int HREG_W     = 16;
  localparam int CREG_W     = 16;

  localparam logic [1:0] REG_IN_WIDTH      = 2'd0;
  localparam logic [1:0] REG_IN_HEIGHT     = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [SLOT_W-1:0] addr;
    logic [31:0]       wdata;
  } mem_req_t;

  typedef struct packed {
    logic        emit;
    logic [31:0] pair_max;
    logic        plane_end;
    logic        tensor_end;
  } pix_info_t;

  function automatic logic is_nan(input logic [31:0] x);
    return x[30:0] > 31'h7F800000;
  endfunction

  function automatic logic [31:0] order_key(input logic [31:0] x);
    return x[31] ? ~x : {1'b1, x[30:0]};
  endfunction

  // The first operand wins unless it is strictly less than the second.
  function automatic logic [31:0] keep_max(input logic [31:0] a, input logic [31:0] b);
    logic lt;
    lt = !is_nan(a) && !is_nan(b) && !(a[30:0] == 31'd0 && b[30:0] == 31'd0) &&
         (order_key(a) < order_key(b));
    return lt ? b : a;
  endfunction

endpackage

// ----- rtl/mp22_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
module mp22_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/mp22_scan.sv -----
// Raster position counters, horizontal pair maximum and line buffer requests.
module mp22_scan
  import mp22_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [31:0]       pixel_bits,
  input  logic [WREG_W-1:0] in_width,
  input  logic [HREG_W-1:0] in_height,
  input  logic [CREG_W-1:0] channel_count,
  output mem_req_t          req,
  output pix_info_t         info
);

  logic [COL_W-1:0]  column_count, column_count_next;
  logic [HREG_W-1:0] row_count, row_count_next;
  logic [CREG_W-1:0] plane_count, plane_count_next;
  logic [31:0]       pair_first;

  logic [WREG_W-1:0] w_eff, w_last, ow2;
  logic [HREG_W-1:0] h_eff, h_last, oh2;
  logic [CREG_W-1:0] ch_last;
  logic              in_window, last_plane;

  always_comb begin
    w_eff = (in_width == '0) ? WREG_W'(1) :
            (in_width > WREG_W'(MAX_WIDTH)) ? WREG_W'(MAX_WIDTH) : in_width;
    h_eff = (in_height == '0) ? HREG_W'(1) : in_height;
    ch_last = (channel_count == '0) ? '0 : channel_count - CREG_W'(1);
    w_last = w_eff - WREG_W'(1);
    h_last = h_eff - HREG_W'(1);
    ow2 = {w_eff[WREG_W-1:1], 1'b0};
    oh2 = {h_eff[HREG_W-1:1], 1'b0};
    in_window = (row_count < oh2) && ({1'b0, column_count} < ow2);
    last_plane = plane_count >= ch_last;
  end

  always_comb begin
    req.addr  = column_count[COL_W-1:1];
    req.wdata = keep_max(pair_first, pixel_bits);
    req.we    = accept && in_window && column_count[0] && !row_count[0];
    req.re    = accept && in_window && column_count[0] && row_count[0];
    info.emit       = req.re;
    info.pair_max   = req.wdata;
    info.plane_end  = (row_count == oh2 - HREG_W'(1)) &&
                      ({1'b0, column_count} == ow2 - WREG_W'(1));
    info.tensor_end = info.plane_end && last_plane;
  end

  always_comb begin
    column_count_next = column_count + COL_W'(1);
    row_count_next    = row_count;
    plane_count_next  = plane_count;
    if ({1'b0, column_count} >= w_last) begin
      column_count_next = '0;
      if (row_count >= h_last) begin
        row_count_next   = '0;
        plane_count_next = last_plane ? '0 : plane_count + CREG_W'(1);
      end else begin
        row_count_next = row_count + HREG_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      plane_count  <= '0;
      pair_first   <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      plane_count  <= plane_count_next;
      if (in_window && !column_count[0]) begin
        pair_first <= pixel_bits;
      end
    end
  end

endmodule

// ----- rtl/max_pool_2x2_stride2_top.sv -----
// 2x2 stride-2 max pooling over float planes with a half-row line buffer.
// A result passes stage one, which waits for the line buffer read, then the output register.
// One pixel per cycle unless the output stalls; at most one line buffer RAM access per pixel.
// Reset clears the position counters, the pipeline and the registers to width 2,
// height 2, one channel; the line buffer is not cleared and needs no clearing pass.
module max_pool_2x2_stride2_top
  import mp22_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  logic [31:0]       pixel_bits,
  output logic              pooled_valid,
  input  logic              pooled_stall,
  output logic [31:0]       pooled_bits,
  output logic              plane_end,
  output logic              tensor_end,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  logic [WREG_W-1:0] in_width;
  logic [HREG_W-1:0] in_height;
  logic [CREG_W-1:0] channel_count;
  logic              advance, accept;
  mem_req_t          req;
  pix_info_t         info, s1;
  logic              s1_valid;
  logic [31:0]       top_max;

  assign cfg_ready   = 1'b1;
  assign advance     = !pooled_valid || !pooled_stall;
  assign pixel_stall = !advance;
  assign accept      = pixel_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width      <= WREG_W'(2);
      in_height     <= HREG_W'(2);
      channel_count <= CREG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IN_WIDTH:      in_width      <= cfg_data[WREG_W-1:0];
        REG_IN_HEIGHT:     in_height     <= cfg_data[HREG_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CREG_W-1:0];
        default: ;
      endcase
    end
  end

  mp22_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .pixel_bits    (pixel_bits),
    .in_width      (in_width),
    .in_height     (in_height),
    .channel_count (channel_count),
    .req           (req),
    .info          (info)
  );

  mp22_ram #(
    .DEPTH (HALF_DEPTH),
    .WIDTH (32)
  ) u_line (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.addr),
    .wdata (req.wdata),
    .re    (req.re),
    .raddr (req.addr),
    .rdata (top_max)
  );

  // Stage one waits for the line buffer read; the output register follows it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      pooled_valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= accept && info.emit;
      pooled_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1 <= info;
      if (s1_valid) begin
        pooled_bits <= keep_max(top_max, s1.pair_max);
        plane_end   <= s1.plane_end;
        tensor_end  <= s1.tensor_end;
      end
    end
  end

endmodule

// ----- test/tb_max_pool_2x2_stride2_top.sv -----
// Self-checking testbench for the streaming 2x2 stride-2 float max pooling block.
module tb_max_pool_2x2_stride2_top;
  import mp22_pkg::*;

  typedef struct {
    logic [31:0] bits;
    logic        pend;
    logic        tend;
  } pooled_t;

  logic        clk;
  logic        rst;
  logic        pixel_valid;
  logic        pixel_stall;
  logic [31:0] pixel_bits;
  logic        pooled_valid;
  logic        pooled_stall;
  logic [31:0] pooled_bits;
  logic        plane_end;
  logic        tensor_end;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  logic [31:0] pixel_q[$];
  pooled_t     window_max_q[$];

  // Shadow copy of the block's registers and position state.
  logic [12:0] width_reg;
  logic [15:0] height_reg;
  logic [15:0] chan_reg;
  logic [11:0] col_pos;
  logic [15:0] row_pos;
  logic [15:0] plane_pos;
  logic [31:0] pair_left;
  logic [31:0] top_max_mem [HALF_DEPTH];

  logic pixel_taken;
  int   accepted_pixels;
  int   received_results;
  int   mismatches;

  max_pool_2x2_stride2_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_bits  (pixel_bits),
    .pooled_valid(pooled_valid),
    .pooled_stall(pooled_stall),
    .pooled_bits (pooled_bits),
    .plane_end   (plane_end),
    .tensor_end  (tensor_end),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic fp_nan(input logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  // Maps a float pattern onto an unsigned scale that follows numeric order.
  function automatic logic [31:0] fp_rank(input logic [31:0] v);
    if (v[31]) begin
      return ~v;
    end
    return v ^ 32'h8000_0000;
  endfunction

  // The earlier operand survives unless it is strictly below the later one.
  function automatic logic [31:0] fp_larger(input logic [31:0] a, input logic [31:0] b);
    logic below;
    below = 1'b0;
    if (!fp_nan(a) && !fp_nan(b) && !(a[30:0] == 31'd0 && b[30:0] == 31'd0)) begin
      below = fp_rank(a) < fp_rank(b);
    end
    return below ? b : a;
  endfunction

  task automatic pool_pixel(input logic [31:0] px);
    int      w;
    int      h;
    int      ch;
    int      ow;
    int      oh;
    int      slot;
    logic    last;
    pooled_t res;
    logic [31:0] pm;
    w  = (width_reg == 0) ? 1 : int'(width_reg);
    h  = (height_reg == 0) ? 1 : int'(height_reg);
    ch = (chan_reg == 0) ? 1 : int'(chan_reg);
    if (w > MAX_WIDTH) begin
      w = MAX_WIDTH;
    end
    ow = w / 2;
    oh = h / 2;
    if (int'(row_pos) < 2 * oh && int'(col_pos) < 2 * ow) begin
      slot = int'(col_pos) >> 1;
      if (!col_pos[0]) begin
        pair_left = px;
      end else begin
        pm = fp_larger(pair_left, px);
        if (!row_pos[0]) begin
          top_max_mem[slot] = pm;
        end else begin
          last = (int'(row_pos) == 2 * oh - 1) && (int'(col_pos) == 2 * ow - 1);
          res.bits = fp_larger(top_max_mem[slot], pm);
          res.pend = last;
          res.tend = last && (int'(plane_pos) >= ch - 1);
          window_max_q.push_back(res);
        end
      end
    end
    if (int'(col_pos) >= w - 1) begin
      col_pos = '0;
      if (int'(row_pos) >= h - 1) begin
        row_pos = '0;
        if (int'(plane_pos) >= ch - 1) begin
          plane_pos = '0;
        end else begin
          plane_pos = plane_pos + 16'd1;
        end
      end else begin
        row_pos = row_pos + 16'd1;
      end
    end else begin
      col_pos = col_pos + 12'd1;
    end
  endtask

  // Predict on every input transfer, then check every output transfer.
  always @(posedge clk) begin
    if (rst) begin
      pixel_taken <= 1'b0;
      col_pos = '0;
      row_pos = '0;
      plane_pos = '0;
      pair_left = '0;
      accepted_pixels = 0;
      received_results = 0;
      mismatches = 0;
    end else begin
      pixel_taken <= pixel_valid && !pixel_stall;
      if (pixel_valid && !pixel_stall) begin
        pool_pixel(pixel_bits);
        accepted_pixels++;
      end
      if (pooled_valid && !pooled_stall) begin
        received_results++;
        if (window_max_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: unexpected result bits=%h plane_end=%b tensor_end=%b",
                     pooled_bits, plane_end, tensor_end);
          end
        end else begin
          pooled_t want;
          want = window_max_q.pop_front();
          if (want.bits !== pooled_bits || want.pend !== plane_end ||
              want.tend !== tensor_end) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: result %0d expected %h/%b/%b got %h/%b/%b",
                       received_results, want.bits, want.pend, want.tend,
                       pooled_bits, plane_end, tensor_end);
            end
          end
        end
      end
    end
  end

  // Quiet window: no idling on either side for a stretch of the random traffic.
  function automatic logic go_idle();
    if (accepted_pixels >= 400 && accepted_pixels < 700) begin
      return 1'b0;
    end
    return $urandom_range(99) < 27;
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      pixel_valid  <= 1'b0;
      pixel_bits   <= '0;
      pooled_stall <= 1'b0;
    end else begin
      pooled_stall <= go_idle();
      if (!pixel_valid || pixel_taken) begin
        if (pixel_q.size() != 0 && !go_idle()) begin
          pixel_valid <= 1'b1;
          pixel_bits  <= pixel_q.pop_front();
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  function automatic logic [31:0] rand_pixel();
    logic [31:0] specials [10];
    specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
                 32'h0000_0001, 32'h8000_0001};
    case ($urandom_range(3))
      0: return specials[$urandom_range(9)];
      1: return {$urandom_range(1) == 1, 8'd127, 20'd0, 3'($urandom_range(7))};
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (pixel_q.size() != 0 || pixel_valid || window_max_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    case (idx)
      REG_IN_WIDTH:      width_reg  = val[12:0];
      REG_IN_HEIGHT:     height_reg = val;
      REG_CHANNEL_COUNT: chan_reg   = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Reconfigures, then queues whole tensors so every phase ends with the counters at zero.
  task automatic run_tensors(input logic [15:0] w, input logic [15:0] h, input logic [15:0] ch,
                             input int tensors);
    int pixels;
    int ew;
    wait_drained();
    write_reg(REG_IN_WIDTH, w);
    write_reg(REG_IN_HEIGHT, h);
    write_reg(REG_CHANNEL_COUNT, ch);
    ew = (width_reg == 0) ? 1 : int'(width_reg);
    if (ew > MAX_WIDTH) begin
      ew = MAX_WIDTH;
    end
    pixels = ew * ((h == 0) ? 1 : int'(h)) * ((ch == 0) ? 1 : int'(ch)) * tensors;
    repeat (pixels) pixel_q.push_back(rand_pixel());
  endtask

  initial begin
    logic [31:0] corner_px [16];
    int random_pixels;
    int w;
    int h;
    int ch;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_IN_WIDTH;
    cfg_data = '0;
    width_reg = 13'd2;
    height_reg = 16'd2;
    chan_reg = 16'd1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: two 2x2 planes, NaN first in one, then NaN second.
    pixel_q = '{32'h7FC0_0000, 32'h3F80_0000, 32'h4000_0000, 32'hBF80_0000,
                32'h3F80_0000, 32'h7FC0_0001, 32'hFF80_0000, 32'h7F80_0000};

    // 4x4: signed zeros, infinities, NaN in three window slots, extremes of the patterns.
    corner_px = '{32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                  32'h0000_0000, 32'h8000_0000, 32'hFF80_0000, 32'h7F7F_FFFF,
                  32'hFF7F_FFFF, 32'h8000_0001, 32'h7F80_0000, 32'h7FC0_0000,
                  32'hFF80_0000, 32'h7FFF_FFFF, 32'h4120_0000, 32'hC120_0000};
    wait_drained();
    write_reg(REG_IN_WIDTH, 16'd4);
    write_reg(REG_IN_HEIGHT, 16'd4);
    write_reg(REG_CHANNEL_COUNT, 16'd1);
    foreach (corner_px[i]) pixel_q.push_back(corner_px[i]);

    run_tensors(16'd0, 16'd0, 16'd0, 2);       // zero registers act as one
    run_tensors(16'd5, 16'd3, 16'd2, 1);       // odd column and odd row dropped
    run_tensors(16'd1, 16'd6, 16'd2, 1);       // planes without windows
    run_tensors(16'd7, 16'd1, 16'd1, 1);
    run_tensors(16'd2, 16'd4, 16'd3, 3);       // back-to-back tensors

    random_pixels = 0;
    while (random_pixels < 850) begin
      w  = $urandom_range(12, 1);
      h  = $urandom_range(8, 1);
      ch = $urandom_range(3, 1);
      run_tensors(16'(w), 16'(h), 16'(ch), 1);
      random_pixels += w * h * ch;
    end

    run_tensors(16'd1, 16'd64, 16'd1, 1);      // tall narrow plane
    run_tensors(16'd1, 16'd1, 16'd64, 1);      // many planes
    run_tensors(16'd3, 16'd2, 16'd2, 1);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && window_max_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
